@@ src/pgd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pgd_pkg;

	// Grid geometry.
	localparam int MAX_COLS = 64;
	localparam int MAX_ROWS = 64;
	localparam int DEPTH    = MAX_COLS * MAX_ROWS;
	localparam int ADDR_W   = $clog2(DEPTH);

	// Field widths.
	localparam int COL_W  = 6;
	localparam int ROW_W  = 6;
	localparam int SIZE_W = 7;
	localparam int VEL_W  = 16;
	localparam int INV_W  = 16;
	localparam int DIV_W  = 26;
	localparam int SUM_W  = VEL_W + 2;
	localparam int PROD_W = SUM_W + INV_W + 1;
	localparam int FRAC_W = 8;

	// Configuration port.
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;
	localparam logic [1:0] REG_COLS = 2'd0;
	localparam logic [1:0] REG_ROWS = 2'd1;
	localparam logic [1:0] REG_INV  = 2'd2;

	localparam logic [SIZE_W-1:0] COLS_RESET = SIZE_W'(64);
	localparam logic [SIZE_W-1:0] ROWS_RESET = SIZE_W'(64);
	localparam logic [INV_W-1:0]  INV_RESET  = INV_W'(128);
	localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(2);

	// Operation codes.
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic                    opcode;
		logic [COL_W-1:0]        col;
		logic [ROW_W-1:0]        row;
		logic signed [VEL_W-1:0] vel_x;
		logic signed [VEL_W-1:0] vel_y;
	} in_item_t;

	typedef struct packed {
		logic signed [DIV_W-1:0] divergence;
		logic [ROW_W-1:0]        out_row;
		logic [COL_W-1:0]        out_col;
		logic                    out_of_range;
	} out_item_t;

	// Effective grid settings, sizes already clamped to their legal range.
	typedef struct packed {
		logic [SIZE_W-1:0] cols;
		logic [SIZE_W-1:0] rows;
		logic [INV_W-1:0]  inv;
	} cfg_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SUM,
		S_MUL
	} state_t;

	// Row-major address of a cell.
	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col);
		return ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_COLS) + ADDR_W'(col));
	endfunction

endpackage

`default_nettype wire

@@ src/pgd_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface pgd_in_if;
	logic               valid;
	logic               ready;
	pgd_pkg::in_item_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ src/pgd_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface pgd_out_if;
	logic               valid;
	logic               ready;
	pgd_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ src/pgd_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

// One write port and two read ports, read data registered.
module pgd_ram #(
	parameter int DATA_W = 16,
	parameter int DEPTH  = 4096,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr_a,
	input  wire logic [ADDR_W-1:0] raddr_b,
	output logic      [DATA_W-1:0] rdata_a,
	output logic      [DATA_W-1:0] rdata_b
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

`default_nettype wire

@@ src/pgd_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pgd_cfg (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [pgd_pkg::PADDR_W-1:0]    paddr,
	input  wire logic [pgd_pkg::PDATA_W-1:0]    pwdata,
	output logic      [pgd_pkg::PDATA_W-1:0]    prdata,
	output logic                                pready,
	output pgd_pkg::cfg_t                       cfg
);

	logic [pgd_pkg::SIZE_W-1:0] cols_q;
	logic [pgd_pkg::SIZE_W-1:0] rows_q;
	logic [pgd_pkg::INV_W-1:0]  inv_q;
	logic [1:0]                 reg_idx;
	logic                       wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[pgd_pkg::PADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;

	// Register writes; an index beyond the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= pgd_pkg::COLS_RESET;
			rows_q <= pgd_pkg::ROWS_RESET;
			inv_q  <= pgd_pkg::INV_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				pgd_pkg::REG_COLS: cols_q <= pwdata[pgd_pkg::SIZE_W-1:0];
				pgd_pkg::REG_ROWS: rows_q <= pwdata[pgd_pkg::SIZE_W-1:0];
				pgd_pkg::REG_INV:  inv_q  <= pwdata[pgd_pkg::INV_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back the raw register values.
	always_comb begin
		case (reg_idx)
			pgd_pkg::REG_COLS: prdata = pgd_pkg::PDATA_W'(cols_q);
			pgd_pkg::REG_ROWS: prdata = pgd_pkg::PDATA_W'(rows_q);
			pgd_pkg::REG_INV:  prdata = pgd_pkg::PDATA_W'(inv_q);
			default:           prdata = '0;
		endcase
	end

	// Clamp the sizes to the range the grid supports.
	always_comb begin
		if (cols_q < pgd_pkg::SIZE_MIN) begin
			cfg.cols = pgd_pkg::SIZE_MIN;
		end else if (cols_q > pgd_pkg::SIZE_W'(pgd_pkg::MAX_COLS)) begin
			cfg.cols = pgd_pkg::SIZE_W'(pgd_pkg::MAX_COLS);
		end else begin
			cfg.cols = cols_q;
		end
		if (rows_q < pgd_pkg::SIZE_MIN) begin
			cfg.rows = pgd_pkg::SIZE_MIN;
		end else if (rows_q > pgd_pkg::SIZE_W'(pgd_pkg::MAX_ROWS)) begin
			cfg.rows = pgd_pkg::SIZE_W'(pgd_pkg::MAX_ROWS);
		end else begin
			cfg.rows = rows_q;
		end
		cfg.inv = inv_q;
	end

endmodule

`default_nettype wire

@@ src/pgd_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pgd_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire pgd_pkg::cfg_t   cfg,
	pgd_in_if.sink               req,
	pgd_out_if.source            rsp
);

	pgd_pkg::state_t state_q, state_d;
	pgd_pkg::in_item_t d;

	logic accept, wr_en, rd_en, in_grid, sum_en, load_out, out_free;

	logic [pgd_pkg::SIZE_W-1:0] col_inc, row_inc, col_top, row_top;
	logic [pgd_pkg::COL_W-1:0]  col_p, col_m;
	logic [pgd_pkg::ROW_W-1:0]  row_p, row_m;

	logic [pgd_pkg::VEL_W-1:0] vx_a, vx_b, vy_a, vy_b;

	logic [pgd_pkg::ROW_W-1:0]         row_s1;
	logic [pgd_pkg::COL_W-1:0]         col_s1;
	logic                              oor_s1;
	logic signed [pgd_pkg::SUM_W-1:0]  sum_s2;
	logic signed [pgd_pkg::SUM_W-1:0]  sum_d;
	logic signed [pgd_pkg::PROD_W-1:0] prod;

	logic               out_valid_q;
	pgd_pkg::out_item_t out_q;

	assign d        = req.data;
	assign accept   = req.valid && req.ready;
	assign in_grid  = ({1'b0, d.col} < cfg.cols) && ({1'b0, d.row} < cfg.rows);
	assign wr_en    = accept && (d.opcode == pgd_pkg::OP_WRITE) && in_grid;
	assign rd_en    = accept && (d.opcode == pgd_pkg::OP_QUERY);
	assign out_free = !out_valid_q || rsp.ready;

	// Neighbor indices with periodic wrap at the used size.
	always_comb begin
		col_inc = {1'b0, d.col} + pgd_pkg::SIZE_W'(1);
		row_inc = {1'b0, d.row} + pgd_pkg::SIZE_W'(1);
		col_top = cfg.cols - pgd_pkg::SIZE_W'(1);
		row_top = cfg.rows - pgd_pkg::SIZE_W'(1);
		col_p   = (col_inc == cfg.cols) ? '0 : col_inc[pgd_pkg::COL_W-1:0];
		row_p   = (row_inc == cfg.rows) ? '0 : row_inc[pgd_pkg::ROW_W-1:0];
		col_m   = (d.col == '0) ? col_top[pgd_pkg::COL_W-1:0] : d.col - pgd_pkg::COL_W'(1);
		row_m   = (d.row == '0) ? row_top[pgd_pkg::ROW_W-1:0] : d.row - pgd_pkg::ROW_W'(1);
	end

	// The x store is read along the row, the y store along the column.
	pgd_ram #(
		.DATA_W (pgd_pkg::VEL_W),
		.DEPTH  (pgd_pkg::DEPTH)
	) u_vx_ram (
		.clk     (clk),
		.we      (wr_en),
		.waddr   (pgd_pkg::cell_addr(d.row, d.col)),
		.wdata   (d.vel_x),
		.re      (rd_en),
		.raddr_a (pgd_pkg::cell_addr(d.row, col_p)),
		.raddr_b (pgd_pkg::cell_addr(d.row, col_m)),
		.rdata_a (vx_a),
		.rdata_b (vx_b)
	);

	pgd_ram #(
		.DATA_W (pgd_pkg::VEL_W),
		.DEPTH  (pgd_pkg::DEPTH)
	) u_vy_ram (
		.clk     (clk),
		.we      (wr_en),
		.waddr   (pgd_pkg::cell_addr(d.row, d.col)),
		.wdata   (d.vel_y),
		.re      (rd_en),
		.raddr_a (pgd_pkg::cell_addr(row_p, d.col)),
		.raddr_b (pgd_pkg::cell_addr(row_m, d.col)),
		.rdata_a (vy_a),
		.rdata_b (vy_b)
	);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pgd_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			pgd_pkg::S_IDLE: if (rd_en) state_d = pgd_pkg::S_SUM;
			pgd_pkg::S_SUM:  state_d = pgd_pkg::S_MUL;
			pgd_pkg::S_MUL:  if (out_free) state_d = pgd_pkg::S_IDLE;
			default:         state_d = pgd_pkg::S_IDLE;
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		req.ready = 1'b0;
		sum_en    = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			pgd_pkg::S_IDLE: req.ready = 1'b1;
			pgd_pkg::S_SUM:  sum_en = 1'b1;
			pgd_pkg::S_MUL:  load_out = out_free;
			default: ;
		endcase
	end

	// Query context is held until the result is loaded.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			row_s1 <= d.row;
			col_s1 <= d.col;
			oor_s1 <= !in_grid;
		end
	end

	// Sum of both central differences.
	assign sum_d = (pgd_pkg::SUM_W'(signed'(vx_a)) - pgd_pkg::SUM_W'(signed'(vx_b)))
	             + (pgd_pkg::SUM_W'(signed'(vy_a)) - pgd_pkg::SUM_W'(signed'(vy_b)));

	always_ff @(posedge clk) begin
		if (sum_en) begin
			sum_s2 <= sum_d;
		end
	end

	// Scale by 1/(2h); dropping the low fraction bits of the signed product floors.
	assign prod = pgd_pkg::PROD_W'(sum_s2) * pgd_pkg::PROD_W'(signed'({1'b0, cfg.inv}));

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.divergence   <= oor_s1 ? '0 :
				prod[pgd_pkg::FRAC_W +: pgd_pkg::DIV_W];
			out_q.out_row      <= row_s1;
			out_q.out_col      <= col_s1;
			out_q.out_of_range <= oor_s1;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

endmodule

`default_nettype wire

@@ src/periodic_grid_divergence_unit.sv @@
// A write's velocity pair is stored at the edge of its transfer.
// A query result is read from the memories, registered as a difference sum, then
// multiplied and loaded into the output register; a query holds off further transfers
// until its result is loaded, longer while an earlier result waits.
// Reset restores the size and scale registers and clears control state; the
// velocity memories are not cleared, so there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module periodic_grid_divergence_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	pgd_in_if.sink                           req,
	pgd_out_if.source                        rsp,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [pgd_pkg::PADDR_W-1:0] paddr,
	input  wire logic [pgd_pkg::PDATA_W-1:0] pwdata,
	output logic      [pgd_pkg::PDATA_W-1:0] prdata,
	output logic                             pready
);

	pgd_pkg::cfg_t cfg;

	// Register file.
	pgd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Memories, sequencer and arithmetic.
	pgd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

@@ src/pgd_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pgd_checker (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 req_valid,
	input wire logic                 req_ready,
	input wire pgd_pkg::in_item_t    req_data,
	input wire logic                 rsp_valid,
	input wire logic                 rsp_ready,
	input wire pgd_pkg::out_item_t   rsp_data
);

	// A result that is not taken holds its value.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("stalled result changed");

	// A query beyond the used size reports a zero divergence.
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.out_of_range |-> rsp_data.divergence == '0)
		else $error("out-of-range result carries a divergence");

	// A write never produces a result.
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_data.opcode == pgd_pkg::OP_WRITE && !rsp_valid
		|=> !rsp_valid)
		else $error("result appeared after a write");

	// A query holds off the next transfer while it is in flight.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_data.opcode == pgd_pkg::OP_QUERY |=> !req_ready)
		else $error("input taken while a query is in flight");

endmodule

bind periodic_grid_divergence_unit pgd_checker u_pgd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.req_data  (req.data),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

`default_nettype wire

@@ bench/divergence_checker.sv @@
`timescale 1ns / 1ps

module divergence_checker
	import pgd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	pgd_in_if                  req,
	pgd_out_if                 rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output int                 fail_count,
	output int                 pending
);

	// Shadow copy of the velocity grid and of the size and scale registers.
	logic signed [VEL_W-1:0] vx_grid [DEPTH];
	logic signed [VEL_W-1:0] vy_grid [DEPTH];
	logic [SIZE_W-1:0]       cols_reg;
	logic [SIZE_W-1:0]       rows_reg;
	logic [INV_W-1:0]        inv_reg;

	// Results owed by the block, oldest query first.
	out_item_t               owed_divergence_q [$];

	// Size registers saturate to 2..top before use.
	function automatic int grid_size(input logic [SIZE_W-1:0] v, input int top);
		if (v < SIZE_MIN)
			return 2;
		if (int'(v) > top)
			return top;
		return int'(v);
	endfunction

	function automatic bit cell_inside(input int c, input int r);
		return c < grid_size(cols_reg, MAX_COLS) && r < grid_size(rows_reg, MAX_ROWS);
	endfunction

	// Central difference with periodic wrap, scaled and floored back to Q18.8.
	function automatic out_item_t divergence_at(input in_item_t it);
		out_item_t res;
		int        cols;
		int        rows;
		int        c;
		int        r;
		int        cp;
		int        cm;
		int        rp;
		int        rm;
		int        dx;
		int        dy;
		longint    prod;
		cols             = grid_size(cols_reg, MAX_COLS);
		rows             = grid_size(rows_reg, MAX_ROWS);
		c                = int'(it.col);
		r                = int'(it.row);
		res.out_row      = it.row;
		res.out_col      = it.col;
		res.out_of_range = 1'b1;
		res.divergence   = '0;
		if (cell_inside(c, r)) begin
			cp = (c + 1 == cols) ? 0 : c + 1;
			cm = (c == 0) ? cols - 1 : c - 1;
			rp = (r + 1 == rows) ? 0 : r + 1;
			rm = (r == 0) ? rows - 1 : r - 1;
			dx = int'(vx_grid[r * MAX_COLS + cp]) - int'(vx_grid[r * MAX_COLS + cm]);
			dy = int'(vy_grid[rp * MAX_COLS + c]) - int'(vy_grid[rm * MAX_COLS + c]);
			prod             = longint'(dx + dy) * longint'(inv_reg);
			res.divergence   = DIV_W'(prod >>> FRAC_W);
			res.out_of_range = 1'b0;
		end
		return res;
	endfunction

	task automatic note_failure(input string msg);
		if (fail_count < 10)
			$display("%0t divergence_checker: %s", $time, msg);
		fail_count++;
	endtask

	// Follow register writes, request transfers and result transfers.
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		out_item_t got;
		if (!arst_n) begin
			cols_reg   = COLS_RESET;
			rows_reg   = ROWS_RESET;
			inv_reg    = INV_RESET;
			owed_divergence_q.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[PADDR_W-1:2])
					REG_COLS: cols_reg = pwdata[SIZE_W-1:0];
					REG_ROWS: rows_reg = pwdata[SIZE_W-1:0];
					REG_INV:  inv_reg  = pwdata[INV_W-1:0];
					default:  ;
				endcase
			end

			if (req.valid && req.ready) begin
				if (req.data.opcode == OP_QUERY) begin
					owed_divergence_q = {owed_divergence_q, divergence_at(req.data)};
				end else if (cell_inside(int'(req.data.col), int'(req.data.row))) begin
					vx_grid[int'(req.data.row) * MAX_COLS + int'(req.data.col)] = req.data.vel_x;
					vy_grid[int'(req.data.row) * MAX_COLS + int'(req.data.col)] = req.data.vel_y;
				end
			end

			if (rsp.valid && rsp.ready) begin
				got = rsp.data;
				if (owed_divergence_q.size() == 0) begin
					note_failure($sformatf("result with no query waiting: div %0d row %0d col %0d oor %0b",
						got.divergence, got.out_row, got.out_col, got.out_of_range));
				end else begin
					want = owed_divergence_q.pop_front();
					if (got.divergence !== want.divergence || got.out_row !== want.out_row ||
							got.out_col !== want.out_col || got.out_of_range !== want.out_of_range) begin
						note_failure($sformatf({"expected div %0d row %0d col %0d oor %0b, ",
							"got div %0d row %0d col %0d oor %0b"},
							want.divergence, want.out_row, want.out_col, want.out_of_range,
							got.divergence, got.out_row, got.out_col, got.out_of_range));
					end
				end
			end
			pending = owed_divergence_q.size();
		end
	end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import pgd_pkg::*;

	localparam int         CLK_HALF        = 4;
	localparam int         RESET_CYCLES    = 10;
	localparam int         HOLD_OFF_CYCLES = 300;
	localparam int         SETTLE_CYCLES   = 8;
	localparam int         CYCLE_LIMIT     = 1000000;
	localparam logic [1:0] REG_SPARE       = 2'd3;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	pgd_in_if  req_if ();
	pgd_out_if rsp_if ();

	int fail_count;
	int pending;
	int cycle_count = 0;

	// Stimulus-side view of the grid: clamped sizes and which cells hold data.
	int grid_cols = 64;
	int grid_rows = 64;
	bit cell_written [DEPTH];
	int items_sent = 0;

	// Idle and stall rates per phase, and the long receiver hold-off request.
	int src_idle_pct = 0;
	int snk_stall_pct = 0;
	bit hold_off_go = 1'b0;

	periodic_grid_divergence_unit DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_if),
		.rsp     (rsp_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	divergence_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_if),
		.rsp        (rsp_if),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #CLK_HALF clk = ~clk;

	// Run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Result side: random stalls, or one long hold-off counted here.
	always begin
		@(negedge clk);
		if (hold_off_go) begin
			hold_off_go = 1'b0;
			rsp_if.ready <= 1'b0;
			repeat (HOLD_OFF_CYCLES) @(negedge clk);
		end else begin
			rsp_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
		end
	end

	function automatic int fit_size(input logic [SIZE_W-1:0] v, input int top);
		if (v < SIZE_MIN)
			return 2;
		if (int'(v) > top)
			return top;
		return int'(v);
	endfunction

	function automatic logic [VEL_W-1:0] rand_vel();
		case ($urandom_range(0, 7))
			0:       return 16'h7FFF;
			1:       return 16'h8000;
			2:       return '0;
			default: return VEL_W'($urandom);
		endcase
	endfunction

	// One request transfer, after a random number of idle cycles.
	task automatic send_item(input in_item_t it);
		bit in_grid;
		in_grid = int'(it.col) < grid_cols && int'(it.row) < grid_rows;
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			req_if.valid <= 1'b0;
			@(negedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data  <= it;
		do @(posedge clk); while (!req_if.ready);
		if (it.opcode == OP_WRITE && in_grid)
			cell_written[int'(it.row) * MAX_COLS + int'(it.col)] = 1'b1;
		if (it.opcode == OP_QUERY || in_grid)
			items_sent++;
	endtask

	task automatic write_cell(input int c, input int r, input logic [VEL_W-1:0] vx,
			input logic [VEL_W-1:0] vy);
		in_item_t it;
		it.opcode = OP_WRITE;
		it.col    = COL_W'(c);
		it.row    = ROW_W'(r);
		it.vel_x  = vx;
		it.vel_y  = vy;
		send_item(it);
	endtask

	// A query inside the grid first gets its four wrapped neighbors written.
	task automatic query_cell(input int c, input int r);
		int       nc [4];
		int       nr [4];
		in_item_t it;
		if (c < grid_cols && r < grid_rows) begin
			nc = '{(c + 1) % grid_cols, (c + grid_cols - 1) % grid_cols, c, c};
			nr = '{r, r, (r + 1) % grid_rows, (r + grid_rows - 1) % grid_rows};
			foreach (nc[k]) begin
				if (!cell_written[nr[k] * MAX_COLS + nc[k]])
					write_cell(nc[k], nr[k], rand_vel(), rand_vel());
			end
		end
		it.opcode = OP_QUERY;
		it.col    = COL_W'(c);
		it.row    = ROW_W'(r);
		it.vel_x  = VEL_W'($urandom);
		it.vel_y  = VEL_W'($urandom);
		send_item(it);
	endtask

	// Drop valid, wait for every owed result, then let the pipeline settle.
	task automatic wait_quiet();
		@(negedge clk);
		req_if.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Setup and access cycles of one register write.
	task automatic apb_write(input logic [1:0] idx, input logic [PDATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (idx == REG_COLS)
			grid_cols = fit_size(data[SIZE_W-1:0], MAX_COLS);
		else if (idx == REG_ROWS)
			grid_rows = fit_size(data[SIZE_W-1:0], MAX_ROWS);
	endtask

	// Unused upper data bits carry noise.
	task automatic set_grid(input int cols, input int rows, input int inv);
		wait_quiet();
		apb_write(REG_COLS, (PDATA_W'($urandom) << SIZE_W) | PDATA_W'(cols));
		apb_write(REG_ROWS, (PDATA_W'($urandom) << SIZE_W) | PDATA_W'(rows));
		apb_write(REG_INV, (PDATA_W'($urandom) << INV_W) | PDATA_W'(inv));
	endtask

	// Writes and valid queries on written neighborhoods, with stray cells mixed in.
	task automatic random_items(input int count);
		int target;
		int pick;
		int c;
		int r;
		target = items_sent + count;
		while (items_sent < target) begin
			pick = $urandom_range(0, 99);
			c    = $urandom_range(0, grid_cols - 1);
			r    = $urandom_range(0, grid_rows - 1);
			if (pick < 30)
				write_cell(c, r, rand_vel(), rand_vel());
			else if (pick < 80)
				query_cell(c, r);
			else if (pick < 92)
				query_cell($urandom_range(0, 63), $urandom_range(0, 63));
			else
				write_cell($urandom_range(0, 63), $urandom_range(0, 63), rand_vel(), rand_vel());
		end
	endtask

	task automatic run_phase(input int cols, input int rows, input int inv, input int src_pct,
			input int snk_pct, input bit hold, input int count);
		set_grid(cols, rows, inv);
		src_idle_pct  = src_pct;
		snk_stall_pct = snk_pct;
		if (hold)
			hold_off_go = 1'b1;
		random_items(count);
	endtask

	initial begin
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		req_if.valid  = 1'b0;
		req_if.data   = '0;
		rsp_if.ready  = 1'b0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// Largest positive differences around the origin, wrapping on both axes.
		write_cell(1, 0, 16'h7FFF, 16'h0000);
		write_cell(63, 0, 16'h8000, 16'h0000);
		write_cell(0, 1, 16'h0000, 16'h7FFF);
		write_cell(0, 63, 16'h0000, 16'h8000);
		query_cell(0, 0);
		query_cell(63, 63);

		// Largest negative differences, then the same at the largest scale.
		write_cell(1, 0, 16'h8000, 16'h0000);
		write_cell(63, 0, 16'h7FFF, 16'h0000);
		write_cell(0, 1, 16'h0000, 16'h8000);
		write_cell(0, 63, 16'h0000, 16'h7FFF);
		query_cell(0, 0);
		set_grid(64, 64, 65535);
		query_cell(0, 0);

		// Oversized and undersized sizes clamp; with two rows, both row neighbors are the same row.
		set_grid(127, 0, 300);
		query_cell(5, 1);
		write_cell(5, 10, 16'h1234, 16'h4321);
		query_cell(5, 10);
		query_cell(63, 63);

		// A write past the register list changes nothing.
		wait_quiet();
		apb_write(REG_SPARE, '1);

		// Zero scale on a two-column grid.
		set_grid(1, 5, 0);
		query_cell(1, 4);
		query_cell(2, 1);
		write_cell(63, 0, 16'h7FFF, 16'h7FFF);

		run_phase(64, 64, 128, 0, 0, 1'b0, 300);
		run_phase(5, 7, 65535, 79, 0, 1'b0, 250);
		run_phase(2, 2, 1, 0, 79, 1'b0, 250);
		run_phase(0, 127, 0, 37, 37, 1'b0, 200);
		run_phase(13, 64, 777, 0, 0, 1'b1, 250);
		run_phase($urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 65535),
			0, 0, 1'b0, 160);
		run_phase($urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 65535),
			79, 0, 1'b0, 160);
		run_phase($urandom_range(2, 16), $urandom_range(2, 16), $urandom_range(0, 65535),
			0, 79, 1'b0, 160);
		run_phase($urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 65535),
			37, 37, 1'b0, 160);

		wait_quiet();
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
